[rtl/ptpd_pkg.sv]
// ----------------------------------------------------------------------------
// ptpd_pkg
// Shared widths, payload types, event codes and helpers of the peak and
// trough period detector.
// ----------------------------------------------------------------------------
package ptpd_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int COUNT_WIDTH  = 32;
   localparam int OUT_WIDTH    = 32;
   localparam int DIV_CNT_W    = $clog2(COUNT_WIDTH + 1);

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_PEAK   = 2'd1,
      EV_TROUGH = 2'd2
   } event_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic                           last;
   } req_type;

   typedef struct packed {
      event_type                      event_res;
      logic signed [SAMPLE_WIDTH-1:0] extreme_value;
      logic [OUT_WIDTH-1:0]           interval;
      logic [OUT_WIDTH-1:0]           position;
      logic                           final_res;
      logic [OUT_WIDTH-1:0]           avg_peak_period;
      logic [OUT_WIDTH-1:0]           avg_trough_period;
   } rsp_type;

   // One classified sample on its way from the front to the back
   typedef struct packed {
      event_type                      event_res;
      logic signed [SAMPLE_WIDTH-1:0] extreme_value;
      logic [OUT_WIDTH-1:0]           interval;
      logic [OUT_WIDTH-1:0]           position;
      logic                           final_res;
      logic [COUNT_WIDTH-1:0]         peak_sum;
      logic [COUNT_WIDTH-1:0]         peak_cnt;
      logic [COUNT_WIDTH-1:0]         trough_sum;
      logic [COUNT_WIDTH-1:0]         trough_cnt;
   } job_type;

   // Add two counter values, clamping at all ones
   function automatic logic [COUNT_WIDTH-1:0] sat_add(
      input logic [COUNT_WIDTH-1:0] a,
      input logic [COUNT_WIDTH-1:0] b
   );
      logic [COUNT_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
   endfunction

   // Present the low output bits of a counter value, zero extended if narrow
   function automatic logic [OUT_WIDTH-1:0] to_out(
      input logic [COUNT_WIDTH-1:0] v
   );
      logic [COUNT_WIDTH+OUT_WIDTH-1:0] t;
      t = {{OUT_WIDTH{1'b0}}, v};
      return t[OUT_WIDTH-1:0];
   endfunction

endpackage

[rtl/ptpd_front.sv]
// ----------------------------------------------------------------------------
// ptpd_front
// Accepts samples, detects peaks and troughs, keeps the running counts and
// interval sums, and pushes one classified job per sample into the queue.
// ----------------------------------------------------------------------------
module ptpd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ptpd_pkg::req_type req_data,
   input  logic              q_full,
   output logic              q_push,
   output ptpd_pkg::job_type q_data
);

   logic signed [ptpd_pkg::SAMPLE_WIDTH-1:0] prev_ff, prev_in;
   logic                                     seek_trough_ff, seek_trough_in;
   logic [ptpd_pkg::COUNT_WIDTH-1:0]         index_ff, index_in;
   logic [ptpd_pkg::COUNT_WIDTH-1:0]         last_peak_ff, last_peak_in;
   logic [ptpd_pkg::COUNT_WIDTH-1:0]         last_trough_ff, last_trough_in;
   logic [ptpd_pkg::COUNT_WIDTH-1:0]         peak_cnt_ff, peak_cnt_in;
   logic [ptpd_pkg::COUNT_WIDTH-1:0]         trough_cnt_ff, trough_cnt_in;
   logic [ptpd_pkg::COUNT_WIDTH-1:0]         peak_sum_ff, peak_sum_in;
   logic [ptpd_pkg::COUNT_WIDTH-1:0]         trough_sum_ff, trough_sum_in;

   logic                             is_peak;
   logic                             is_trough;
   logic [ptpd_pkg::COUNT_WIDTH-1:0] peak_itv;
   logic [ptpd_pkg::COUNT_WIDTH-1:0] trough_itv;

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;

   // Classify the sample against the previous one and form the next state
   always_comb begin
      is_peak    = !seek_trough_ff && (req_data.sample < prev_ff);
      is_trough  = seek_trough_ff && (req_data.sample > prev_ff);
      peak_itv   = index_ff - last_peak_ff;
      trough_itv = index_ff - last_trough_ff;

      prev_in        = req_data.sample;
      seek_trough_in = seek_trough_ff;
      index_in       = ptpd_pkg::sat_add(index_ff, ptpd_pkg::COUNT_WIDTH'(1));
      last_peak_in   = last_peak_ff;
      last_trough_in = last_trough_ff;
      peak_cnt_in    = peak_cnt_ff;
      trough_cnt_in  = trough_cnt_ff;
      peak_sum_in    = peak_sum_ff;
      trough_sum_in  = trough_sum_ff;

      q_data.event_res     = ptpd_pkg::EV_NONE;
      q_data.extreme_value = '0;
      q_data.interval      = '0;
      q_data.position      = ptpd_pkg::to_out(index_ff);
      q_data.final_res     = req_data.last;

      if (is_peak) begin
         seek_trough_in       = 1'b1;
         last_peak_in         = index_ff;
         peak_cnt_in          = ptpd_pkg::sat_add(peak_cnt_ff, ptpd_pkg::COUNT_WIDTH'(1));
         peak_sum_in          = ptpd_pkg::sat_add(peak_sum_ff, peak_itv);
         q_data.event_res     = ptpd_pkg::EV_PEAK;
         q_data.extreme_value = prev_ff;
         q_data.interval      = ptpd_pkg::to_out(peak_itv);
      end else if (is_trough) begin
         seek_trough_in       = 1'b0;
         last_trough_in       = index_ff;
         trough_cnt_in        = ptpd_pkg::sat_add(trough_cnt_ff, ptpd_pkg::COUNT_WIDTH'(1));
         trough_sum_in        = ptpd_pkg::sat_add(trough_sum_ff, trough_itv);
         q_data.event_res     = ptpd_pkg::EV_TROUGH;
         q_data.extreme_value = prev_ff;
         q_data.interval      = ptpd_pkg::to_out(trough_itv);
      end

      // Snapshot includes this sample's event
      q_data.peak_sum   = peak_sum_in;
      q_data.peak_cnt   = peak_cnt_in;
      q_data.trough_sum = trough_sum_in;
      q_data.trough_cnt = trough_cnt_in;
   end

   // Advance detector state on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff        <= '0;
         seek_trough_ff <= 1'b0;
         index_ff       <= '0;
         last_peak_ff   <= '0;
         last_trough_ff <= '0;
         peak_cnt_ff    <= '0;
         trough_cnt_ff  <= '0;
         peak_sum_ff    <= '0;
         trough_sum_ff  <= '0;
      end else if (q_push) begin
         prev_ff        <= prev_in;
         seek_trough_ff <= seek_trough_in;
         index_ff       <= index_in;
         last_peak_ff   <= last_peak_in;
         last_trough_ff <= last_trough_in;
         peak_cnt_ff    <= peak_cnt_in;
         trough_cnt_ff  <= trough_cnt_in;
         peak_sum_ff    <= peak_sum_in;
         trough_sum_ff  <= trough_sum_in;
      end
   end

endmodule

[rtl/ptpd_queue.sv]
// ----------------------------------------------------------------------------
// ptpd_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module ptpd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ptpd_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output ptpd_pkg::job_type head
);

   ptpd_pkg::job_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;

   assign full       = (fill_ff == 2'd2);
   assign head_valid = (fill_ff != 2'd0);
   assign head       = entry_ff[rd_ptr_ff];

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/ptpd_div.sv]
// ----------------------------------------------------------------------------
// ptpd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptpd_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [ptpd_pkg::COUNT_WIDTH-1:0] dividend,
   input  logic [ptpd_pkg::COUNT_WIDTH-1:0] divisor,
   output logic                             done,
   output logic [ptpd_pkg::COUNT_WIDTH-1:0] quotient
);

   logic [ptpd_pkg::COUNT_WIDTH-1:0] rem_ff, rem_in;
   logic [ptpd_pkg::COUNT_WIDTH-1:0] quo_ff, quo_in;
   logic [ptpd_pkg::COUNT_WIDTH-1:0] den_ff, den_in;
   logic [ptpd_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                             done_ff, done_in;

   logic [ptpd_pkg::COUNT_WIDTH:0]   shifted;
   logic [ptpd_pkg::COUNT_WIDTH:0]   diff;

   assign done     = done_ff;
   assign quotient = quo_ff;

   // One trial subtraction per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[ptpd_pkg::COUNT_WIDTH-1]};
      diff    = shifted - {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = ptpd_pkg::DIV_CNT_W'(ptpd_pkg::COUNT_WIDTH);
         done_in = 1'b0;
      end else if (cnt_ff != '0) begin
         if (!diff[ptpd_pkg::COUNT_WIDTH]) begin
            rem_in = diff[ptpd_pkg::COUNT_WIDTH-1:0];
            quo_in = {quo_ff[ptpd_pkg::COUNT_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[ptpd_pkg::COUNT_WIDTH-1:0];
            quo_in = {quo_ff[ptpd_pkg::COUNT_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - ptpd_pkg::DIV_CNT_W'(1);
         if (cnt_ff == ptpd_pkg::DIV_CNT_W'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

endmodule

[rtl/ptpd_back.sv]
// ----------------------------------------------------------------------------
// ptpd_back
// Takes jobs from the queue, forms the averages on a final sample and
// holds each result in the output register until it is taken.
// ----------------------------------------------------------------------------
module ptpd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  ptpd_pkg::job_type q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ptpd_pkg::rsp_type rsp_data
);

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_DIV  = 2'b10
   } back_state_type;

   back_state_type    state_ff, state_in;
   ptpd_pkg::job_type job_ff, job_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ptpd_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                             out_free;
   logic                             div_start;
   logic                             peak_done;
   logic                             trough_done;
   logic [ptpd_pkg::COUNT_WIDTH-1:0] peak_quo;
   logic [ptpd_pkg::COUNT_WIDTH-1:0] trough_quo;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   ptpd_div u_peak_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (q_head.peak_sum),
      .divisor  (q_head.peak_cnt),
      .done     (peak_done),
      .quotient (peak_quo)
   );

   ptpd_div u_trough_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (q_head.trough_sum),
      .divisor  (q_head.trough_cnt),
      .done     (trough_done),
      .quotient (trough_quo)
   );

   // Sequence jobs into the output register
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid && q_head.final_res) begin
               q_pop     = 1'b1;
               div_start = 1'b1;
               job_in    = q_head;
               state_in  = BK_DIV;
            end else if (q_valid && out_free) begin
               q_pop                         = 1'b1;
               rsp_valid_in                  = 1'b1;
               rsp_data_in.event_res         = q_head.event_res;
               rsp_data_in.extreme_value     = q_head.extreme_value;
               rsp_data_in.interval          = q_head.interval;
               rsp_data_in.position          = q_head.position;
               rsp_data_in.final_res         = 1'b0;
               rsp_data_in.avg_peak_period   = '0;
               rsp_data_in.avg_trough_period = '0;
            end
         end
         BK_DIV: begin
            if (peak_done && trough_done && out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.event_res     = job_ff.event_res;
               rsp_data_in.extreme_value = job_ff.extreme_value;
               rsp_data_in.interval      = job_ff.interval;
               rsp_data_in.position      = job_ff.position;
               rsp_data_in.final_res     = 1'b1;
               // Empty count averages to zero
               rsp_data_in.avg_peak_period =
                  (job_ff.peak_cnt == '0) ? '0 : ptpd_pkg::to_out(peak_quo);
               rsp_data_in.avg_trough_period =
                  (job_ff.trough_cnt == '0) ? '0 : ptpd_pkg::to_out(trough_quo);
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[rtl/peak_trough_period_detector.sv]
// ----------------------------------------------------------------------------
// peak_trough_period_detector
// A plain sample's result passes the queue and the output register; a
// last-flagged one also waits on the bit-serial dividers of the averages.
// Throughput: one sample per cycle between last-flagged samples while the
// queue has room and results are taken; a last-flagged sample holds the back
// end until both dividers are done and the output register is free.
// Reset clears detector state, counters, queue and output register at once.
// ----------------------------------------------------------------------------
module peak_trough_period_detector (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ptpd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ptpd_pkg::rsp_type rsp_data
);

   logic              q_full;
   logic              q_push;
   ptpd_pkg::job_type q_push_data;
   logic              q_pop;
   logic              q_valid;
   ptpd_pkg::job_type q_head;

   ptpd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_push_data)
   );

   ptpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head       (q_head)
   );

   ptpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
